### rtl/ppc_pkg.sv
`timescale 1ns / 1ps
// Shared sizes, types and codes of the polygon point containment block.
// Depends on nothing; every other file but ppc_ram imports it.
package ppc_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int COORD_BITS   = 32;

   // Fixed widths of the channel fields.
   localparam int FIELD_BITS = 32;
   localparam int TOTAL_BITS = 11;

   localparam int COORD_W   = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
   localparam int DIFF_BITS = COORD_W + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int VERT_BITS = 2 * COORD_W;
   localparam int ADDR_BITS = $clog2(MAX_VERTICES);
   localparam int CNT_BITS  = $clog2(MAX_VERTICES + 1);
   localparam int HITS_BITS = $clog2(2 * MAX_VERTICES + 1) + 1;

   typedef logic [1:0] func_type;

   localparam func_type FUNC_CLEAR  = 2'd0;
   localparam func_type FUNC_APPEND = 2'd1;
   localparam func_type FUNC_TEST   = 2'd2;

   typedef logic signed [COORD_W-1:0]   coord_type;
   typedef logic signed [DIFF_BITS-1:0] diff_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // Crossing count steps.
   localparam logic signed [2:0] DELTA_NONE = 3'sd0;
   localparam logic signed [2:0] DELTA_UP   = 3'sd1;
   localparam logic signed [2:0] DELTA_DOWN = -3'sd1;
   localparam logic signed [2:0] DELTA_FULL = 3'sd2;

   // A vertex relative to the test point.
   typedef struct packed {
      diff_type dx;
      diff_type dy;
   } rel_point_type;

   // What one edge contributes to the test.
   typedef struct packed {
      logic             on_edge;
      logic             need_cross;
      logic signed [2:0] delta;
   } edge_class_type;

endpackage

### rtl/ppc_req_if.sv
`timescale 1ns / 1ps
// Request channel: operation code and one coordinate pair per beat.
// Depends on ppc_pkg.
interface ppc_req_if import ppc_pkg::*; ();
   logic                         valid;
   logic                         ready;
   func_type                     func;
   logic signed [FIELD_BITS-1:0] x_coord;
   logic signed [FIELD_BITS-1:0] y_coord;

   modport source (output valid, func, x_coord, y_coord, input ready);
   modport sink   (input valid, func, x_coord, y_coord, output ready);
endinterface

### rtl/ppc_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: containment answer, store status and vertex count per beat.
// Depends on ppc_pkg.
interface ppc_rsp_if import ppc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  inside_res;
   logic                  status;
   logic [TOTAL_BITS-1:0] vertex_total;

   modport source (output valid, inside_res, status, vertex_total, input ready);
   modport sink   (input valid, inside_res, status, vertex_total, output ready);
endinterface

### rtl/ppc_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module ppc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/ppc_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product, used for both cross product terms.
// Depends on ppc_pkg.
module ppc_mul import ppc_pkg::*; (
   input  logic     clock,
   input  diff_type mul_a,
   input  diff_type mul_b,
   output prod_type prod
);
   prod_type prod_ff;
   prod_type prod_in;

   assign prod_in = prod_type'(mul_a) * prod_type'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule

### rtl/ppc_edge.sv
`timescale 1ns / 1ps
// Classifies one polygon edge, shifted so the test point is the origin.
// Depends on ppc_pkg.
module ppc_edge import ppc_pkg::*; (
   input  rel_point_type  prev,
   input  rel_point_type  cur,
   output edge_class_type cls
);
   logic zx1, nx1, px1, zy1, ny1, py1;
   logic zx2, nx2, px2, zy2, ny2, py2;

   assign zx1 = (prev.dx == '0);
   assign nx1 = prev.dx[DIFF_BITS-1];
   assign px1 = !zx1 && !nx1;
   assign zy1 = (prev.dy == '0);
   assign ny1 = prev.dy[DIFF_BITS-1];
   assign py1 = !zy1 && !ny1;
   assign zx2 = (cur.dx == '0);
   assign nx2 = cur.dx[DIFF_BITS-1];
   assign px2 = !zx2 && !nx2;
   assign zy2 = (cur.dy == '0);
   assign ny2 = cur.dy[DIFF_BITS-1];
   assign py2 = !zy2 && !ny2;

   always_comb begin
      cls.on_edge    = 1'b0;
      cls.need_cross = 1'b0;
      cls.delta      = DELTA_NONE;
      priority if (zy1 && zy2) begin
         // Horizontal edge on the point's row: inside if the ends straddle or touch it.
         cls.on_edge = zx1 || zx2 || (nx1 != nx2);
      end else if (zy1) begin
         if (zx1) begin
            cls.on_edge = 1'b1;
         end else if (px1) begin
            cls.delta = py2 ? DELTA_UP : DELTA_DOWN;
         end
      end else if (zy2) begin
         if (zx2) begin
            cls.on_edge = 1'b1;
         end else if (px2) begin
            cls.delta = ny1 ? DELTA_UP : DELTA_DOWN;
         end
      end else if (py1 != py2) begin
         if (px1 && px2) begin
            cls.delta = DELTA_FULL;
         end else if (zx1 || zx2 || (nx1 != nx2)) begin
            cls.need_cross = 1'b1;
         end
      end else begin
         // Both ends strictly on the same side of the point's row: no crossing.
         cls.delta = DELTA_NONE;
      end
   end
endmodule

### rtl/polygon_point_containment.sv
`timescale 1ns / 1ps
// Top level of the polygon point containment block: sequencer, vertex store, result register.
// Depends on ppc_pkg, ppc_req_if, ppc_rsp_if, ppc_ram, ppc_mul and ppc_edge.

// The block holds one polygon of up to MAX_VERTICES vertices and answers one response beat
// for every request beat. A clear or an append is done in the cycle it is accepted, and its
// result passes the pending stage to the output register; an append to a full store is
// dropped and reported with status set, and a point test that is rejected at once (fewer
// than two vertices, or the point lies outside the running bounding box) goes the same way.
// Otherwise the test walks every edge, closing edge included, reading one vertex per cycle
// outside the cross product states from the single read port of the vertex store. An edge
// that straddles the point's row with ends on both sides of the point's column, or one on
// it, needs a cross product sign from the one shared multiplier. A point on an edge or a
// vertex ends the walk early and answers inside. The request side is not ready while a test
// runs or while a finished result still waits to move into the output register. The vertex
// store needs no clearing pass after reset: a test only uses entries below the vertex count.
module polygon_point_containment import ppc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   ppc_req_if.sink       req_chan,
   ppc_rsp_if.source     rsp_chan
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_FIRST = 6'b000010,
      ST_EDGE  = 6'b000100,
      ST_MUL1  = 6'b001000,
      ST_MUL2  = 6'b010000,
      ST_CMP   = 6'b100000
   } state_type;

   typedef logic signed [HITS_BITS-1:0] hits_type;

   state_type              state_ff, state_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]    idx_ff, idx_in;
   coord_type              box_x_min_ff, box_x_min_in;
   coord_type              box_x_max_ff, box_x_max_in;
   coord_type              box_y_min_ff, box_y_min_in;
   coord_type              box_y_max_ff, box_y_max_in;
   coord_type              px_ff, px_in;
   coord_type              py_ff, py_in;
   rel_point_type          first_ff, first_in;
   rel_point_type          prev_ff, prev_in;
   rel_point_type          cur_ff, cur_in;
   hits_type               hits_ff, hits_in;
   prod_type               p_ff, p_in;
   logic                   pend_ff, pend_in;
   logic                   pend_inside_ff, pend_inside_in;
   logic                   pend_status_ff, pend_status_in;
   logic                   rsp_valid_ff;
   logic                   rsp_inside_ff;
   logic                   rsp_status_ff;
   logic [TOTAL_BITS-1:0]  rsp_total_ff;

   logic                   req_fire;
   logic                   rsp_load;
   coord_type              in_x, in_y;
   logic                   out_of_box;
   logic                   wr_en;
   logic [VERT_BITS-1:0]   rd_data;
   rel_point_type          rel_rd;
   rel_point_type          cur_rel;
   logic                   last_edge;
   edge_class_type         cls;
   diff_type               mul_a, mul_b;
   prod_type               prod;
   logic                   fin;
   logic                   fin_inside;
   logic                   fin_status;
   logic                   adv;
   hits_type               adv_hits;
   hits_type               adv_abs;
   rel_point_type          adv_cur;

   assign req_chan.ready = (state_ff == ST_IDLE) && !pend_ff;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Coordinates live in the low COORD_W bits of the fields.
   assign in_x = coord_type'(req_chan.x_coord[COORD_W-1:0]);
   assign in_y = coord_type'(req_chan.y_coord[COORD_W-1:0]);

   assign out_of_box = (in_x < box_x_min_ff) || (in_x > box_x_max_ff) ||
                       (in_y < box_y_min_ff) || (in_y > box_y_max_ff);

   // Vertex store, each word holds y above x. The read address follows the next edge
   // index, so the read data always belongs to the current index.
   ppc_ram #(
      .WIDTH (VERT_BITS),
      .DEPTH (MAX_VERTICES)
   ) u_vert_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[ADDR_BITS-1:0]),
      .wr_data ({in_y, in_x}),
      .rd_addr (idx_in[ADDR_BITS-1:0]),
      .rd_data (rd_data)
   );

   assign rel_rd.dx = diff_type'(coord_type'(rd_data[COORD_W-1:0])) - diff_type'(px_ff);
   assign rel_rd.dy = diff_type'(coord_type'(rd_data[VERT_BITS-1:COORD_W])) - diff_type'(py_ff);

   // Once the index reaches the count, the edge closes back onto the first vertex.
   assign last_edge = (idx_ff == cnt_ff);
   assign cur_rel   = last_edge ? first_ff : rel_rd;

   ppc_edge u_edge (
      .prev (prev_ff),
      .cur  (cur_rel),
      .cls  (cls)
   );

   // First pass forms x1*y2, second pass x2*y1.
   assign mul_a = (state_ff == ST_MUL1) ? prev_ff.dx : cur_ff.dx;
   assign mul_b = (state_ff == ST_MUL1) ? cur_ff.dy  : prev_ff.dy;

   ppc_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign adv_abs = adv_hits[HITS_BITS-1] ? -adv_hits : adv_hits;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      box_x_min_in = box_x_min_ff;
      box_x_max_in = box_x_max_ff;
      box_y_min_in = box_y_min_ff;
      box_y_max_in = box_y_max_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      first_in     = first_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      hits_in      = hits_ff;
      p_in         = p_ff;
      wr_en        = 1'b0;
      fin          = 1'b0;
      fin_inside   = 1'b0;
      fin_status   = 1'b0;
      adv          = 1'b0;
      adv_hits     = hits_ff;
      adv_cur      = cur_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_chan.func)
                  FUNC_CLEAR: begin
                     cnt_in       = '0;
                     box_x_min_in = COORD_MAX;
                     box_y_min_in = COORD_MAX;
                     box_x_max_in = COORD_MIN;
                     box_y_max_in = COORD_MIN;
                     fin          = 1'b1;
                  end
                  FUNC_APPEND: begin
                     fin = 1'b1;
                     if (cnt_ff == CNT_BITS'(MAX_VERTICES)) begin
                        fin_status = 1'b1;
                     end else begin
                        wr_en  = 1'b1;
                        cnt_in = cnt_ff + 1'b1;
                        if (in_x < box_x_min_ff) box_x_min_in = in_x;
                        if (in_y < box_y_min_ff) box_y_min_in = in_y;
                        if (in_x > box_x_max_ff) box_x_max_in = in_x;
                        if (in_y > box_y_max_ff) box_y_max_in = in_y;
                     end
                  end
                  FUNC_TEST: begin
                     px_in = in_x;
                     py_in = in_y;
                     if ((cnt_ff <= CNT_BITS'(1)) || out_of_box) begin
                        fin = 1'b1;
                     end else begin
                        idx_in   = '0;
                        hits_in  = '0;
                        state_in = ST_FIRST;
                     end
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         ST_FIRST: begin
            first_in = rel_rd;
            prev_in  = rel_rd;
            idx_in   = CNT_BITS'(1);
            state_in = ST_EDGE;
         end
         ST_EDGE: begin
            cur_in = cur_rel;
            priority if (cls.on_edge) begin
               fin        = 1'b1;
               fin_inside = 1'b1;
               state_in   = ST_IDLE;
            end else if (cls.need_cross) begin
               state_in = ST_MUL1;
            end else begin
               adv      = 1'b1;
               adv_hits = hits_ff + hits_type'(cls.delta);
               adv_cur  = cur_rel;
            end
         end
         ST_MUL1: begin
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            p_in     = prod;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // The product register now holds x2*y1, p_ff holds x1*y2.
            if (p_ff == prod) begin
               fin        = 1'b1;
               fin_inside = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               adv     = 1'b1;
               adv_cur = cur_ff;
               if ((p_ff > prod) == !cur_ff.dy[DIFF_BITS-1]) begin
                  adv_hits = hits_ff + hits_type'(DELTA_FULL);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Move to the next edge, or finish after the closing edge. The answer is the
      // second bit of the crossing sum's magnitude.
      if (adv) begin
         hits_in = adv_hits;
         if (last_edge) begin
            fin        = 1'b1;
            fin_inside = adv_abs[1];
            state_in   = ST_IDLE;
         end else begin
            prev_in  = adv_cur;
            idx_in   = idx_ff + 1'b1;
            state_in = ST_EDGE;
         end
      end
   end

   // A finished result waits in the pending stage until the output register is free.
   assign rsp_load       = pend_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign pend_in        = fin ? 1'b1 : (rsp_load ? 1'b0 : pend_ff);
   assign pend_inside_in = fin ? fin_inside : pend_inside_ff;
   assign pend_status_in = fin ? fin_status : pend_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         box_x_min_ff <= COORD_MAX;
         box_y_min_ff <= COORD_MAX;
         box_x_max_ff <= COORD_MIN;
         box_y_max_ff <= COORD_MIN;
         hits_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         box_x_min_ff <= box_x_min_in;
         box_y_min_ff <= box_y_min_in;
         box_x_max_ff <= box_x_max_in;
         box_y_max_ff <= box_y_max_in;
         hits_ff      <= hits_in;
         pend_ff      <= pend_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      px_ff          <= px_in;
      py_ff          <= py_in;
      first_ff       <= first_in;
      prev_ff        <= prev_in;
      cur_ff         <= cur_in;
      p_ff           <= p_in;
      pend_inside_ff <= pend_inside_in;
      pend_status_ff <= pend_status_in;
      if (rsp_load) begin
         rsp_inside_ff <= pend_inside_ff;
         rsp_status_ff <= pend_status_ff;
         rsp_total_ff  <= TOTAL_BITS'(cnt_ff);
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.inside_res   = rsp_inside_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.vertex_total = rsp_total_ff;

   // The vertex count never passes the store depth.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(MAX_VERTICES))
      else $error("vertex count beyond store depth");

   // An edge walk only starts with the pending stage empty.
   a_walk_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !pend_ff)
      else $error("result pending during edge walk");

   // The edge index holds while the multiplier works on the current edge.
   a_mul_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL1) |=> ($stable(idx_ff) && (state_ff == ST_MUL2)))
      else $error("edge index moved during cross product");

   // A dropped append reports a full store.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_total_ff == TOTAL_BITS'(MAX_VERTICES)))
      else $error("store full status with a count below depth");

endmodule

### verif/polygon_point_containment_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of polygon_point_containment: driver, monitor and predictor.
// Depends on ppc_pkg, ppc_req_if, ppc_rsp_if and the block's RTL.
module polygon_point_containment_test;
   import ppc_pkg::*;

   // The fourth selector value is unused by the block and must leave all state alone.
   localparam func_type FUNC_UNUSED = 2'd3;

   localparam int RESET_CYCLES    = 10;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 40;
   localparam int PHASE_ITEMS     = 130;

   // How both sides of the block pace themselves while a given beat is in flight.
   typedef enum {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH, PACE_HOLD} pace_type;

   typedef struct {
      func_type  func;
      coord_type x;
      coord_type y;
      pace_type  pace;
   } request_type;

   typedef struct {
      logic                  in_poly;
      logic                  status;
      logic [TOTAL_BITS-1:0] total;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ppc_req_if req_bus ();
   ppc_rsp_if rsp_bus ();

   polygon_point_containment u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Pending request beats, filled once at time zero, and the answers still owed by the block.
   request_type work_queue [$];
   answer_type  answers_due [$];

   // The pacing mode of the most recently accepted request; the response side follows it.
   pace_type rsp_pace = PACE_FREE;

   // Vertices the generator has appended since its last clear, so that probe points can be
   // placed on vertices, on edges and on the rows of vertices.
   coord_type gen_x [$];
   coord_type gen_y [$];
   pace_type  gen_pace = PACE_FREE;
   int        queued_total = 0;

   // Shadow of the block's polygon: vertex store, count and running bounding box.
   coord_type poly_x [MAX_VERTICES];
   coord_type poly_y [MAX_VERTICES];
   int        poly_count = 0;
   coord_type box_x_lo = COORD_MAX;
   coord_type box_x_hi = COORD_MIN;
   coord_type box_y_lo = COORD_MAX;
   coord_type box_y_hi = COORD_MIN;

   int error_count    = 0;
   int accepted_count = 0;
   int tests_sent     = 0;
   int inside_count   = 0;
   int dropped_count  = 0;
   int peak_total     = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int sign_of(longint v);
      if (v > 0) return 1;
      if (v < 0) return -1;
      return 0;
   endfunction

   // Applies one request to the shadow polygon and returns the answer the block owes for it.
   // A point test shifts every edge so that the point is the origin and sums signed crossings
   // of the positive x axis: a half crossing when an end lies on the axis, a full one when the
   // edge straddles it to the right. Where the ends are not strictly on one side of the y axis,
   // the crossing's side comes from the sign of x1*y2 - x2*y1 against the edge's direction,
   // exact in wide integers. Any hit on the boundary settles the answer as inside at once.
   function automatic answer_type apply_request(request_type it);
      answer_type ans;
      coord_type px, py;
      longint x1, y1, x2, y2;
      int sx1, sx2, sy1, sy2, hits, i, j, turn;
      logic signed [PROD_BITS+1:0] lhs, rhs;
      bit on_rim;
      px = it.x;
      py = it.y;
      ans.in_poly = 1'b0;
      ans.status = 1'b0;
      case (it.func)
         FUNC_CLEAR: begin
            poly_count = 0;
            box_x_lo = COORD_MAX;
            box_y_lo = COORD_MAX;
            box_x_hi = COORD_MIN;
            box_y_hi = COORD_MIN;
         end
         FUNC_APPEND: begin
            if (poly_count >= MAX_VERTICES) begin
               ans.status = 1'b1;
            end else begin
               poly_x[poly_count] = px;
               poly_y[poly_count] = py;
               poly_count++;
               if (px < box_x_lo) box_x_lo = px;
               if (py < box_y_lo) box_y_lo = py;
               if (px > box_x_hi) box_x_hi = px;
               if (py > box_y_hi) box_y_hi = py;
            end
         end
         FUNC_TEST: begin
            hits = 0;
            on_rim = 1'b0;
            // Degenerate polygons and points outside the box answer outside without a walk.
            if (poly_count >= 2 && px >= box_x_lo && px <= box_x_hi &&
                py >= box_y_lo && py <= box_y_hi) begin
               for (i = 0; i < poly_count && !on_rim; i++) begin
                  j = (i + 1 == poly_count) ? 0 : i + 1;
                  x1 = longint'(poly_x[i]) - longint'(px);
                  y1 = longint'(poly_y[i]) - longint'(py);
                  x2 = longint'(poly_x[j]) - longint'(px);
                  y2 = longint'(poly_y[j]) - longint'(py);
                  sx1 = sign_of(x1);
                  sx2 = sign_of(x2);
                  sy1 = sign_of(y1);
                  sy2 = sign_of(y2);
                  if (sy1 == 0 && sy2 == 0) begin
                     // A horizontal edge on the point's row: inside if it spans the point.
                     if (sx1 * sx2 <= 0) on_rim = 1'b1;
                  end else if (sy1 == 0) begin
                     if (sx1 == 0) on_rim = 1'b1;
                     else if (sx1 > 0) hits += (sy2 > 0) ? 1 : -1;
                  end else if (sy2 == 0) begin
                     if (sx2 == 0) on_rim = 1'b1;
                     else if (sx2 > 0) hits += (sy1 < 0) ? 1 : -1;
                  end else if (sy1 != sy2) begin
                     if (sx1 > 0 && sx2 > 0) begin
                        hits += 2;
                     end else if (sx1 * sx2 <= 0) begin
                        lhs = x1 * y2;
                        rhs = x2 * y1;
                        turn = (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
                        if (turn == 0) on_rim = 1'b1;
                        else if (turn == ((sy2 > 0) ? 1 : -1)) hits += 2;
                     end
                  end
               end
               ans.in_poly = on_rim || ((((hits < 0) ? -hits : hits) / 2) % 2 == 1);
            end
         end
         default: begin
         end
      endcase
      ans.total = TOTAL_BITS'(poly_count);
      return ans;
   endfunction

   // Adds one beat to the pending queue and keeps the generator's copy of the polygon current.
   task automatic queue_req(func_type f, coord_type x, coord_type y);
      request_type it;
      it.func = f;
      it.x = x;
      it.y = y;
      it.pace = gen_pace;
      work_queue.push_back(it);
      queued_total++;
      if (f == FUNC_CLEAR) begin
         gen_x.delete();
         gen_y.delete();
      end else if (f == FUNC_APPEND && gen_x.size() < MAX_VERTICES) begin
         gen_x.push_back(x);
         gen_y.push_back(y);
      end
   endtask

   // A coordinate within spread of center; the sum wraps like the block's 32-bit fields.
   function automatic coord_type near(coord_type center, int unsigned spread);
      return center + coord_type'($urandom_range(0, 2 * spread)) - coord_type'(spread);
   endfunction

   function automatic bit sender_rests(pace_type m);
      case (m)
         PACE_SEND_IDLE: return $urandom_range(0, 99) < 80;
         PACE_BOTH:      return $urandom_range(0, 99) < 20;
         default:        return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls(pace_type m);
      case (m)
         PACE_RECV_STALL: return $urandom_range(0, 99) < 80;
         PACE_BOTH:       return $urandom_range(0, 99) < 20;
         default:         return 1'b0;
      endcase
   endfunction

   // Stimulus. Everything is queued at time zero; the driver then paces it out.
   initial begin : stimulus
      pace_type    phases [4];
      coord_type   center, px, py;
      int unsigned spread;
      int          n, k, j, pick, phase_start;

      phases = '{PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH};

      // Directed beats: an empty and a one-vertex polygon, the unused selector, a square at
      // the coordinate extremes with probes on a vertex and on edges, a large triangle whose
      // diagonal forces the widest cross products, and a flat two-vertex polygon whose only
      // row is the point's own row, with probes both on it and past the box.
      gen_pace = PACE_FREE;
      queue_req(FUNC_CLEAR, 0, 0);
      queue_req(FUNC_TEST, 0, 0);
      queue_req(FUNC_UNUSED, COORD_MAX, COORD_MIN);
      queue_req(FUNC_APPEND, COORD_MIN, COORD_MIN);
      queue_req(FUNC_TEST, COORD_MIN, COORD_MIN);
      queue_req(FUNC_APPEND, COORD_MAX, COORD_MIN);
      queue_req(FUNC_APPEND, COORD_MAX, COORD_MAX);
      queue_req(FUNC_APPEND, COORD_MIN, COORD_MAX);
      queue_req(FUNC_TEST, 0, 0);
      queue_req(FUNC_TEST, COORD_MIN, COORD_MIN);
      queue_req(FUNC_TEST, COORD_MAX, 0);
      queue_req(FUNC_TEST, 5, COORD_MIN);
      queue_req(FUNC_CLEAR, -1, -1);
      queue_req(FUNC_APPEND, COORD_MIN, COORD_MIN);
      queue_req(FUNC_APPEND, COORD_MAX, COORD_MAX);
      queue_req(FUNC_APPEND, COORD_MIN, COORD_MAX);
      queue_req(FUNC_TEST, 0, 0);
      queue_req(FUNC_TEST, 1, 0);
      queue_req(FUNC_TEST, 0, 1);
      queue_req(FUNC_CLEAR, 0, 0);
      queue_req(FUNC_APPEND, 0, 0);
      queue_req(FUNC_APPEND, 10, 0);
      queue_req(FUNC_TEST, 5, 0);
      queue_req(FUNC_TEST, 11, 0);
      queue_req(FUNC_TEST, 5, 1);

      // A short burst during which the response side holds off for a long stretch.
      gen_pace = PACE_HOLD;
      queue_req(FUNC_CLEAR, 0, 0);
      repeat (6) queue_req(FUNC_APPEND, near(0, 64), near(0, 64));
      repeat (5) queue_req(FUNC_TEST, near(0, 64), near(0, 64));

      // Random beats, one pacing phase after another. Most are well-formed: a clear, a
      // polygon of mostly small size, then probes placed where the walk has decisions to make.
      // The rest are stray beats of every kind with fully random fields.
      foreach (phases[p]) begin
         gen_pace = phases[p];
         phase_start = queued_total;
         while (queued_total - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
               queue_req(FUNC_CLEAR, $urandom, $urandom);
               case ($urandom_range(0, 9))
                  0:       n = $urandom_range(0, 1);
                  1:       n = $urandom_range(9, 24);
                  default: n = $urandom_range(2, 8);
               endcase
               case ($urandom_range(0, 3))
                  0:       spread = 4;
                  1:       spread = 64;
                  2:       spread = 1 << 20;
                  default: spread = 1 << 30;
               endcase
               center = ($urandom_range(0, 2) == 0) ? coord_type'($urandom) : '0;
               repeat (n) queue_req(FUNC_APPEND, near(center, spread), near(center, spread));
               repeat ($urandom_range(1, 5)) begin
                  pick = (gen_x.size() > 0) ? $urandom_range(0, 4) : 4;
                  k = (gen_x.size() > 0) ? $urandom_range(0, gen_x.size() - 1) : 0;
                  j = (gen_x.size() > 0) ? (k + 1) % gen_x.size() : 0;
                  case (pick)
                     0: begin
                        px = gen_x[k];
                        py = gen_y[k];
                     end
                     1: begin
                        px = coord_type'((longint'(gen_x[k]) + longint'(gen_x[j])) >>> 1);
                        py = coord_type'((longint'(gen_y[k]) + longint'(gen_y[j])) >>> 1);
                     end
                     2: begin
                        px = near(center, spread);
                        py = gen_y[k];
                     end
                     3: begin
                        px = $urandom;
                        py = $urandom;
                     end
                     default: begin
                        px = near(center, spread);
                        py = near(center, spread);
                     end
                  endcase
                  queue_req(FUNC_TEST, px, py);
               end
            end else begin
               case ($urandom_range(0, 3))
                  0:       queue_req(FUNC_UNUSED, $urandom, $urandom);
                  1:       queue_req(FUNC_APPEND, $urandom, $urandom);
                  2:       queue_req(FUNC_TEST, $urandom, $urandom);
                  default: queue_req(FUNC_CLEAR, $urandom, $urandom);
               endcase
            end
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Wait for every beat to go in and every answer to come out, then let the block settle
      // so that a stray extra response beat would still be caught.
      wait (work_queue.size() == 0 && answers_due.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d request beats: %0d point tests (%0d inside), %0d dropped appends,",
               accepted_count, tests_sent, inside_count, dropped_count);
      $display("vertex count peaked at %0d, under free, idle, stalled and held-off pacing.",
               peak_total);
      if (error_count == 0) begin
         $display("polygon_point_containment_test: done, clean");
      end else begin
         $display("polygon_point_containment_test: done, errors");
      end
      $finish;
   end

   // Driver. A beat stays on the channel until it is taken; the prediction is made at the
   // accepting edge, where the pre-edge values of valid and ready are what the block saw.
   // Valid gets at most one nonblocking assignment per edge, so a beat that follows a
   // taken one directly is never dropped and raised again in the same step.
   always @(posedge clock) begin : req_driver
      bit offer_held;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            answers_due.push_back(apply_request(work_queue[0]));
            rsp_pace <= work_queue[0].pace;
            if (work_queue[0].func == FUNC_TEST) tests_sent++;
            work_queue.pop_front();
            accepted_count++;
            offer_held = 1'b0;
         end else begin
            offer_held = req_bus.valid;
         end
         if (!offer_held) begin
            if (work_queue.size() > 0 && !sender_rests(work_queue[0].pace)) begin
               req_bus.valid   <= 1'b1;
               req_bus.func    <= work_queue[0].func;
               req_bus.x_coord <= work_queue[0].x;
               req_bus.y_coord <= work_queue[0].y;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor and response-side pacing. Each response beat is checked field by field against
   // the oldest owed answer. The first time a held-off beat is accepted upstream, ready stays
   // low for a long counted stretch so that the block backs up and stalls its request side.
   always @(posedge clock) begin : rsp_monitor
      answer_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (answers_due.size() == 0) begin
               $error("response beat with no request outstanding");
               error_count++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_bus.inside_res !== want.in_poly) begin
                  $error("inside_res: expected %0d, got %0d", want.in_poly, rsp_bus.inside_res);
                  error_count++;
               end
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                  error_count++;
               end
               if (rsp_bus.vertex_total !== want.total) begin
                  $error("vertex_total: expected %0d, got %0d", want.total,
                         rsp_bus.vertex_total);
                  error_count++;
               end
               if (want.in_poly) inside_count++;
               if (want.status) dropped_count++;
               if (want.total > peak_total) peak_total = want.total;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_pace == PACE_HOLD && !hold_done) begin
            hold_left = HOLD_OFF_CYCLES - 1;
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !receiver_stalls(rsp_pace);
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      #10_000_000;
      $display("polygon_point_containment_test: done, errors");
      $finish;
   end

endmodule
